// ----- rtl/esa_pkg.sv -----
package esa_pkg;

   localparam int MAX_SLOTS = 64;
   localparam int ROW_W     = 8;
   localparam int ROW_N     = (MAX_SLOTS + ROW_W - 1) / ROW_W;
   localparam int ROW_AW    = (ROW_N > 1) ? $clog2(ROW_N) : 1;
   localparam int BIT_AW    = $clog2(ROW_W);
   localparam int PC_W      = BIT_AW + 1;
   localparam int SID_W     = ROW_AW + BIT_AW;
   localparam int ACT_W     = 4;
   localparam int ID_W      = 7;
   localparam int RID_W     = 6;
   localparam int CNT_W     = 7;

   typedef enum logic [ACT_W-1:0] {
      ACT_RESERVE   = 4'd0,
      ACT_ALLOC     = 4'd1,
      ACT_PEEK      = 4'd2,
      ACT_ADD_POS   = 4'd3,
      ACT_ADD_MOVE  = 4'd4,
      ACT_RM_POS    = 4'd5,
      ACT_RM_MOVE   = 4'd6,
      ACT_RM_ENTITY = 4'd7,
      ACT_QUERY     = 4'd8,
      ACT_LIST_POS  = 4'd9,
      ACT_LIST_MOVE = 4'd10,
      ACT_LIST_BOTH = 4'd11,
      ACT_COUNT     = 4'd12
   } action_type;

   // one memory row: eight slots, three flags each
   typedef struct packed {
      logic [ROW_W-1:0] res;
      logic [ROW_W-1:0] pos;
      logic [ROW_W-1:0] mov;
   } row_type;

   typedef struct packed {
      logic              rd_en;
      logic [ROW_AW-1:0] rd_addr;
      logic              wr_en;
      logic [ROW_AW-1:0] wr_addr;
      row_type           wr_data;
   } mem_req_type;

   function automatic logic [PC_W-1:0] popcount_row(input logic [ROW_W-1:0] v);
      logic [PC_W-1:0] c;
      c = '0;
      for (int i = 0; i < ROW_W; i++) begin
         c = c + PC_W'(v[i]);
      end
      return c;
   endfunction

   function automatic logic [BIT_AW-1:0] lowest_set(input logic [ROW_W-1:0] v);
      logic [BIT_AW-1:0] r;
      r = '0;
      for (int i = ROW_W - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BIT_AW'(i);
         end
      end
      return r;
   endfunction

   // slots of a row that lie below the active count
   function automatic logic [ROW_W-1:0] row_span(input logic [ROW_AW-1:0] row,
                                                 input logic [CNT_W-1:0]  n);
      logic [ROW_W-1:0] m;
      logic [SID_W-1:0] sid;
      m = '0;
      for (int j = 0; j < ROW_W; j++) begin
         sid  = {row, BIT_AW'(j)};
         m[j] = (CNT_W'(sid) < n);
      end
      return m;
   endfunction

endpackage

// ----- rtl/esa_chan_if.sv -----
interface esa_req_if import esa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ACT_W-1:0] action;
   logic [ID_W-1:0]  entity_id;

   modport source (output valid, action, entity_id, input ready);
   modport sink   (input valid, action, entity_id, output ready);
endinterface

interface esa_rsp_if import esa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             ok;
   logic [RID_W-1:0] result_id;
   logic             slot_free;
   logic             has_position;
   logic             has_movement;
   logic [CNT_W-1:0] reserved_total;
   logic [CNT_W-1:0] free_total;
   logic             last;

   modport source (output valid, ok, result_id, slot_free, has_position, has_movement,
                   reserved_total, free_total, last, input ready);
   modport sink   (input valid, ok, result_id, slot_free, has_position, has_movement,
                   reserved_total, free_total, last, output ready);
endinterface

interface esa_csr_if import esa_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CNT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/esa_row_mem.sv -----
module esa_row_mem import esa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mem_req_type mem_req,
   output row_type     rd_row
);

   row_type           mem_ff [ROW_N];
   row_type           rd_data_ff;
   logic [ROW_N-1:0]  row_valid_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_ff[mem_req.rd_addr];
      end
   end

   // a row never written reads as all clear
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (mem_req.wr_en) begin
            row_valid_ff[mem_req.wr_addr] <= 1'b1;
         end
         if (mem_req.rd_en) begin
            rd_valid_ff <= row_valid_ff[mem_req.rd_addr];
         end
      end
   end

   assign rd_row = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/entity_slot_allocator.sv -----
// channel   port        dir   payload
// request   req_chan    in    action, entity_id
// response  rsp_chan    out   ok, result_id, slot_free, has_position, has_movement,
//                             reserved_total, free_total, last
// config    csr_chan    in    slot count (always ready)
//
// Each request sweeps the eight rows of the slot memory through its single read
// port, one row a cycle, then applies any change and pushes its result word.
// Lists sweep the rows again, reading each row and then emitting its listed ids.
// A finished word waits in the response register; a stalled response holds the
// sequencer before its next push. Synchronous reset clears control and marks all
// memory rows empty, so no clearing pass is needed.
module entity_slot_allocator import esa_pkg::*; (
   input logic        clock,
   input logic        reset,
   esa_req_if.sink    req_chan,
   esa_rsp_if.source  rsp_chan,
   esa_csr_if.sink    csr_chan
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_SCAN  = 7'b0000010,
      ST_APPLY = 7'b0000100,
      ST_LRD   = 7'b0001000,
      ST_LGET  = 7'b0010000,
      ST_LEMIT = 7'b0100000,
      ST_LEND  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   action_type        act_ff, act_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              in_range_ff, in_range_in;
   logic [ROW_AW-1:0] row_ff, row_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              found_ff, found_in;
   logic [RID_W-1:0]  found_id_ff, found_id_in;
   logic [ROW_AW-1:0] mod_row_ff, mod_row_in;
   logic [BIT_AW-1:0] mod_bit_ff, mod_bit_in;
   row_type           mod_data_ff, mod_data_in;
   logic [ROW_W-1:0]  lbits_ff, lbits_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [RID_W-1:0]  pend_id_ff, pend_id_in;
   logic [CNT_W-1:0]  slot_count_ff;

   logic              rsp_valid_ff;
   logic              rsp_ok_ff;
   logic [RID_W-1:0]  rsp_id_ff;
   logic              rsp_sf_ff;
   logic              rsp_hp_ff;
   logic              rsp_hm_ff;
   logic [CNT_W-1:0]  rsp_res_ff;
   logic [CNT_W-1:0]  rsp_free_ff;
   logic              rsp_last_ff;

   logic              push;
   logic              push_ok;
   logic [RID_W-1:0]  push_id;
   logic              push_sf;
   logic              push_hp;
   logic              push_hm;
   logic [CNT_W-1:0]  push_res;
   logic              push_last;

   mem_req_type       mem_req;
   row_type           rd_row;

   logic [CNT_W-1:0]  n_eff;
   logic              out_free;
   logic              accept;
   logic              row_last;
   logic [ROW_W-1:0]  span;
   logic [ROW_W-1:0]  free_bits;
   logic              is_find;
   logic              is_list;
   logic              tgt_ok;
   logic [ROW_W-1:0]  sel;
   row_type           new_row;
   logic              res_old;
   logic [ROW_W-1:0]  list_bits;
   logic [BIT_AW-1:0] low_bit;

   esa_row_mem u_row_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_row  (rd_row)
   );

   assign n_eff    = (slot_count_ff > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : slot_count_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign accept   = req_chan.valid && req_chan.ready;
   assign row_last = (row_ff == ROW_AW'(ROW_N - 1));
   assign span     = row_span(row_ff, n_eff);
   assign free_bits = ~rd_row.res & span;
   assign is_find  = (act_ff == ACT_ALLOC) || (act_ff == ACT_PEEK);
   assign is_list  = (act_ff == ACT_LIST_POS) || (act_ff == ACT_LIST_MOVE) ||
                     (act_ff == ACT_LIST_BOTH);
   assign tgt_ok   = is_find ? found_ff : in_range_ff;
   assign sel      = ROW_W'(1) << mod_bit_ff;
   assign res_old  = mod_data_ff.res[mod_bit_ff];
   assign low_bit  = lowest_set(lbits_ff);

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   always_comb begin
      unique case (act_ff)
         ACT_LIST_POS:  list_bits = rd_row.pos;
         ACT_LIST_MOVE: list_bits = rd_row.mov;
         default:       list_bits = rd_row.pos & rd_row.mov;
      endcase
   end

   // modified target row
   always_comb begin
      new_row = mod_data_ff;
      unique case (act_ff)
         ACT_RESERVE, ACT_ALLOC: begin
            new_row.res = mod_data_ff.res | sel;
         end
         ACT_ADD_POS: begin
            new_row.res = mod_data_ff.res | sel;
            new_row.pos = mod_data_ff.pos | sel;
         end
         ACT_ADD_MOVE: begin
            new_row.res = mod_data_ff.res | sel;
            new_row.mov = mod_data_ff.mov | sel;
         end
         ACT_RM_POS, ACT_RM_MOVE, ACT_RM_ENTITY: begin
            if (act_ff != ACT_RM_MOVE) begin
               new_row.pos = mod_data_ff.pos & ~sel;
            end
            if (act_ff != ACT_RM_POS) begin
               new_row.mov = mod_data_ff.mov & ~sel;
            end
            if (!new_row.pos[mod_bit_ff] && !new_row.mov[mod_bit_ff]) begin
               new_row.res = mod_data_ff.res & ~sel;
            end
         end
         default: begin
            new_row = mod_data_ff;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      id_in         = id_ff;
      in_range_in   = in_range_ff;
      row_in        = row_ff;
      cnt_in        = cnt_ff;
      found_in      = found_ff;
      found_id_in   = found_id_ff;
      mod_row_in    = mod_row_ff;
      mod_bit_in    = mod_bit_ff;
      mod_data_in   = mod_data_ff;
      lbits_in      = lbits_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;

      mem_req       = '0;
      push          = 1'b0;
      push_ok       = 1'b0;
      push_id       = '0;
      push_sf       = 1'b0;
      push_hp       = 1'b0;
      push_hm       = 1'b0;
      push_res      = cnt_ff;
      push_last     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               act_in        = action_type'(req_chan.action);
               id_in         = req_chan.entity_id;
               in_range_in   = (req_chan.entity_id < n_eff);
               row_in        = '0;
               cnt_in        = '0;
               found_in      = 1'b0;
               found_id_in   = '0;
               mod_row_in    = req_chan.entity_id[BIT_AW +: ROW_AW];
               mod_bit_in    = req_chan.entity_id[BIT_AW-1:0];
               mem_req.rd_en = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // rd_row holds row row_ff; fetch the next one
            cnt_in = cnt_ff + CNT_W'(popcount_row(rd_row.res & span));
            if (is_find) begin
               if (!found_ff && (free_bits != '0)) begin
                  found_in    = 1'b1;
                  found_id_in = RID_W'({row_ff, lowest_set(free_bits)});
                  mod_row_in  = row_ff;
                  mod_bit_in  = lowest_set(free_bits);
                  mod_data_in = rd_row;
               end
            end else if (row_ff == mod_row_ff) begin
               mod_data_in = rd_row;
            end
            if (row_last) begin
               state_in = ST_APPLY;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = row_ff + ROW_AW'(1);
               row_in          = row_ff + ROW_AW'(1);
            end
         end
         ST_APPLY: begin
            if (is_list) begin
               row_in        = '0;
               pend_valid_in = 1'b0;
               state_in      = ST_LRD;
            end else if (out_free) begin
               push      = 1'b1;
               push_last = 1'b1;
               unique case (act_ff)
                  ACT_RESERVE, ACT_ALLOC, ACT_ADD_POS, ACT_ADD_MOVE,
                  ACT_RM_POS, ACT_RM_MOVE, ACT_RM_ENTITY: begin
                     push_ok = tgt_ok;
                     if (tgt_ok) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = mod_row_ff;
                        mem_req.wr_data = new_row;
                        if (!res_old && new_row.res[mod_bit_ff]) begin
                           cnt_in = cnt_ff + CNT_W'(1);
                        end else if (res_old && !new_row.res[mod_bit_ff]) begin
                           cnt_in = cnt_ff - CNT_W'(1);
                        end
                     end
                     if (act_ff == ACT_ALLOC) begin
                        push_id = found_id_ff;
                     end
                  end
                  ACT_PEEK: begin
                     push_ok = found_ff;
                     push_id = found_id_ff;
                  end
                  ACT_QUERY: begin
                     push_ok = in_range_ff;
                     push_sf = in_range_ff && !mod_data_ff.res[mod_bit_ff];
                     push_hp = in_range_ff && mod_data_ff.pos[mod_bit_ff];
                     push_hm = in_range_ff && mod_data_ff.mov[mod_bit_ff];
                  end
                  ACT_COUNT: begin
                     push_ok = 1'b1;
                  end
                  default: begin
                     push_ok = 1'b0;
                  end
               endcase
               push_res = cnt_in;
               state_in = ST_IDLE;
            end
         end
         ST_LRD: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = row_ff;
            state_in        = ST_LGET;
         end
         ST_LGET: begin
            lbits_in = list_bits & span;
            state_in = ST_LEMIT;
         end
         ST_LEMIT: begin
            // hold one match back so the final one can carry last
            if (lbits_ff != '0) begin
               if (!pend_valid_ff || out_free) begin
                  push          = pend_valid_ff;
                  push_ok       = 1'b1;
                  push_id       = pend_id_ff;
                  pend_valid_in = 1'b1;
                  pend_id_in    = RID_W'({row_ff, low_bit});
                  lbits_in      = lbits_ff & ~(ROW_W'(1) << low_bit);
               end
            end else if (row_last) begin
               state_in = ST_LEND;
            end else begin
               row_in   = row_ff + ROW_AW'(1);
               state_in = ST_LRD;
            end
         end
         ST_LEND: begin
            if (out_free) begin
               push      = 1'b1;
               push_ok   = pend_valid_ff;
               push_id   = pend_valid_ff ? pend_id_ff : '0;
               push_last = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         slot_count_ff <= CNT_W'(64);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            slot_count_ff <= csr_chan.data;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      id_ff       <= id_in;
      in_range_ff <= in_range_in;
      row_ff      <= row_in;
      cnt_ff      <= cnt_in;
      found_ff    <= found_in;
      found_id_ff <= found_id_in;
      mod_row_ff  <= mod_row_in;
      mod_bit_ff  <= mod_bit_in;
      mod_data_ff <= mod_data_in;
      lbits_ff    <= lbits_in;
      pend_id_ff  <= pend_id_in;
      if (push) begin
         rsp_ok_ff   <= push_ok;
         rsp_id_ff   <= push_id;
         rsp_sf_ff   <= push_sf;
         rsp_hp_ff   <= push_hp;
         rsp_hm_ff   <= push_hm;
         rsp_res_ff  <= push_res;
         rsp_free_ff <= n_eff - push_res;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.ok             = rsp_ok_ff;
   assign rsp_chan.result_id      = rsp_id_ff;
   assign rsp_chan.slot_free      = rsp_sf_ff;
   assign rsp_chan.has_position   = rsp_hp_ff;
   assign rsp_chan.has_movement   = rsp_hm_ff;
   assign rsp_chan.reserved_total = rsp_res_ff;
   assign rsp_chan.free_total     = rsp_free_ff;
   assign rsp_chan.last           = rsp_last_ff;

   a_write_in_apply: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> state_ff == ST_APPLY)
      else $error("slot memory written outside apply");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (push && push_last) |=> state_ff == ST_IDLE)
      else $error("final word pushed but sequencer not idle");

   a_full_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && $past(state_ff) == ST_SCAN)
         |-> $past(row_ff) == ROW_AW'(ROW_N - 1))
      else $error("apply entered before the last row was scanned");

endmodule
